// ===== sv/mvm_pkg.sv =====
// Shared types and constants for the matrix-vector multiply block.
package mvm_pkg;

    // Field widths
    localparam int MVM_VAL_W   = 16;
    localparam int MVM_IDX_W   = 10;
    localparam int MVM_CNT_W   = 11;
    localparam int MVM_PROD_W  = 32;
    localparam int MVM_SUM_W   = 48;

    // Largest row length and row count a register may select
    localparam logic [MVM_CNT_W-1:0] MVM_COUNT_LIMIT = 11'd1024;

    // Configuration register indexes
    localparam logic MVM_CFG_COLS = 1'b0;
    localparam logic MVM_CFG_ROWS = 1'b1;

    // Queue between front and back
    localparam int MVM_Q_DEPTH = 4;
    localparam int MVM_QPTR_W  = $clog2(MVM_Q_DEPTH);
    localparam int MVM_QCNT_W  = $clog2(MVM_Q_DEPTH + 1);

    // Item mode codes
    localparam logic MVM_MODE_LOAD   = 1'b0;
    localparam logic MVM_MODE_MATRIX = 1'b1;

    // One matrix operation handed from front to back
    typedef struct packed {
        logic signed [MVM_VAL_W-1:0] value;
        logic signed [MVM_VAL_W-1:0] vec;
        logic                        end_row;
        logic [MVM_IDX_W-1:0]        row_index;
        logic                        last_row;
    } t_mvm_entry;

endpackage

// ===== sv/mvm_in_if.sv =====
// Input channel: vector loads and matrix elements.
interface mvm_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic [9:0]         index;
    logic signed [15:0] value;

    modport source (output valid, output mode, output index, output value, input ready);
    modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

// ===== sv/mvm_out_if.sv =====
// Output channel: one row sum per finished row.
interface mvm_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] row_sum;
    logic [9:0]         row_index;
    logic               last_row;

    modport source (output valid, output row_sum, output row_index, output last_row,
                    input ready);
    modport sink   (input valid, input row_sum, input row_index, input last_row,
                    output ready);
endinterface

// ===== sv/matrix_vector_multiply.sv =====
// Top level of the streamed matrix-vector multiply block.
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        mode, index[9:0], value[15:0] (Q8.8)
//  o_out     out  valid/ready        row_sum[47:0] (Q32.16), row_index[9:0], last_row
//  i_cfg_*   in   write enable only  index 0 cols_in_use, 1 rows_in_use, data[10:0]
//
//  One transaction per clock is sustained while the queue has room.
//  Each matrix element costs one multiply-accumulate. The edge that accepts the element
//  closing the row starts the store read; queue, multiply register and output register
//  follow in that order, and a stalled output can hold the row sum in either register.
//  Reset clears counters, accumulator and queue; the vector store is not cleared.
//  A stalled output holds the back end; the four-entry queue keeps the front taking items until it fills.
module matrix_vector_multiply #(
    parameter int MAX_COLS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mvm_in_if.sink                        i_in,
    mvm_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [mvm_pkg::MVM_CNT_W-1:0] i_cfg_data
);
    import mvm_pkg::*;

    logic [MVM_CNT_W-1:0]  r_cols_cfg, r_rows_cfg;
    logic                  push, q_valid, back_ready;
    t_mvm_entry            push_entry, q_entry;
    logic [MVM_QCNT_W-1:0] q_count;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols_cfg <= MVM_COUNT_LIMIT;
            r_rows_cfg <= MVM_COUNT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                MVM_CFG_COLS: r_cols_cfg <= i_cfg_data;
                MVM_CFG_ROWS: r_rows_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mvm_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cols_cfg (r_cols_cfg),
        .i_rows_cfg (r_rows_cfg),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    mvm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_valid (q_valid),
        .o_entry (q_entry),
        .i_ready (back_ready),
        .o_count (q_count)
    );

    mvm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (q_entry),
        .o_ready (back_ready),
        .o_out   (o_out)
    );
endmodule

// ===== sv/mvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mvm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/mvm_front.sv =====
// Front end: accepts items, writes the vector store, tracks row and column, reads operands.
module mvm_front #(
    parameter int MAX_COLS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mvm_in_if.sink                         i_in,
    input  logic [mvm_pkg::MVM_CNT_W-1:0]  i_cols_cfg,
    input  logic [mvm_pkg::MVM_CNT_W-1:0]  i_rows_cfg,
    input  logic [mvm_pkg::MVM_QCNT_W-1:0] i_q_count,
    output logic                           o_push,
    output mvm_pkg::t_mvm_entry            o_entry
);
    import mvm_pkg::*;

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam logic [MVM_CNT_W-1:0] COL_LIMIT =
        (MAX_COLS < 1024) ? MVM_CNT_W'(MAX_COLS) : MVM_COUNT_LIMIT;

    logic [MVM_IDX_W-1:0] r_col_cnt, n_col_cnt;
    logic [MVM_IDX_W-1:0] r_row_cnt, n_row_cnt;

    logic                        r_s1_valid;
    logic signed [MVM_VAL_W-1:0] r_s1_value;
    logic                        r_s1_end;
    logic [MVM_IDX_W-1:0]        r_s1_row;
    logic                        r_s1_last;
    logic                        r_s1_vok;

    logic                 accept, load_acc, mat_acc;
    logic [MVM_CNT_W-1:0] cols_eff, rows_eff, col_next, row_next;
    logic                 end_row, last_row, load_ok, read_ok;
    logic [ADDR_W-1:0]    waddr, raddr;
    logic [MVM_VAL_W-1:0] rdata;

    // Take a transaction only when the queue has room for it and the one in flight
    assign i_in.ready = (i_q_count + MVM_QCNT_W'(r_s1_valid)) < MVM_QCNT_W'(MVM_Q_DEPTH);
    assign accept     = i_in.valid && i_in.ready;
    assign load_acc   = accept && (i_in.mode == MVM_MODE_LOAD);
    assign mat_acc    = accept && (i_in.mode == MVM_MODE_MATRIX);

    // Clamp the configured counts
    always_comb begin
        if (i_cols_cfg == '0) begin
            cols_eff = MVM_CNT_W'(1);
        end else if (i_cols_cfg > COL_LIMIT) begin
            cols_eff = COL_LIMIT;
        end else begin
            cols_eff = i_cols_cfg;
        end
        if (i_rows_cfg == '0) begin
            rows_eff = MVM_CNT_W'(1);
        end else if (i_rows_cfg > MVM_COUNT_LIMIT) begin
            rows_eff = MVM_COUNT_LIMIT;
        end else begin
            rows_eff = i_rows_cfg;
        end
    end

    // Classify the matrix element: row end and final row
    assign col_next = {1'b0, r_col_cnt} + MVM_CNT_W'(1);
    assign row_next = {1'b0, r_row_cnt} + MVM_CNT_W'(1);
    assign end_row  = col_next >= cols_eff;
    assign last_row = row_next >= rows_eff;

    // Store addressing; loads past the store are dropped
    assign load_ok = 32'(i_in.index) < 32'(MAX_COLS);
    assign read_ok = 32'(r_col_cnt) < 32'(MAX_COLS);
    assign waddr   = ADDR_W'(i_in.index);
    assign raddr   = ADDR_W'(r_col_cnt);

    mvm_ram #(
        .WIDTH (MVM_VAL_W),
        .DEPTH (MAX_COLS)
    ) u_vec_store (
        .i_clk   (i_clk),
        .i_we    (load_acc && load_ok),
        .i_waddr (waddr),
        .i_wdata (i_in.value),
        .i_re    (mat_acc),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // Advance the column and row counters
    always_comb begin
        n_col_cnt = r_col_cnt;
        n_row_cnt = r_row_cnt;
        if (mat_acc) begin
            if (end_row) begin
                n_col_cnt = '0;
                n_row_cnt = last_row ? '0 : row_next[MVM_IDX_W-1:0];
            end else begin
                n_col_cnt = col_next[MVM_IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt  <= '0;
            r_row_cnt  <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_col_cnt  <= n_col_cnt;
            r_row_cnt  <= n_row_cnt;
            r_s1_valid <= mat_acc;
        end
    end

    // Hold the element while the store read completes
    always_ff @(posedge i_clk) begin
        if (mat_acc) begin
            r_s1_value <= i_in.value;
            r_s1_end   <= end_row;
            r_s1_row   <= r_row_cnt;
            r_s1_last  <= last_row;
            r_s1_vok   <= read_ok;
        end
    end

    assign o_push            = r_s1_valid;
    assign o_entry.value     = r_s1_value;
    assign o_entry.vec       = r_s1_vok ? $signed(rdata) : '0;
    assign o_entry.end_row   = r_s1_end;
    assign o_entry.row_index = r_s1_row;
    assign o_entry.last_row  = r_s1_last;
endmodule

// ===== sv/mvm_queue.sv =====
// Short queue of matrix operations between front and back.
module mvm_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  mvm_pkg::t_mvm_entry            i_entry,
    output logic                           o_valid,
    output mvm_pkg::t_mvm_entry            o_entry,
    input  logic                           i_ready,
    output logic [mvm_pkg::MVM_QCNT_W-1:0] o_count
);
    import mvm_pkg::*;

    t_mvm_entry              r_slot [MVM_Q_DEPTH];
    logic [MVM_QPTR_W-1:0]   r_wptr, r_rptr;
    logic [MVM_QCNT_W-1:0]   r_count, n_count;
    logic                    pop;

    assign o_valid = r_count != '0;
    assign o_entry = r_slot[r_rptr];
    assign o_count = r_count;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + MVM_QCNT_W'(1);
        end else if (!i_push && pop) begin
            n_count = r_count - MVM_QCNT_W'(1);
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= r_wptr + MVM_QPTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + MVM_QPTR_W'(1);
            end
        end
    end

    // Store the pushed operation
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end
endmodule

// ===== sv/mvm_back.sv =====
// Back end: multiply, accumulate each row, hold the row sum for the output channel.
module mvm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  mvm_pkg::t_mvm_entry i_entry,
    output logic                o_ready,
    mvm_out_if.source           o_out
);
    import mvm_pkg::*;

    logic                         r_m_valid;
    logic signed [MVM_PROD_W-1:0] r_m_prod;
    logic                         r_m_end;
    logic [MVM_IDX_W-1:0]         r_m_row;
    logic                         r_m_last;

    logic signed [MVM_SUM_W-1:0]  r_acc;
    logic                         r_out_valid;
    logic signed [MVM_SUM_W-1:0]  r_out_sum;
    logic [MVM_IDX_W-1:0]         r_out_row;
    logic                         r_out_last;

    logic                         out_free, m_adv, take;
    logic signed [MVM_SUM_W-1:0]  sum;

    // A row end waits only for a free output register
    assign out_free = !r_out_valid || o_out.ready;
    assign m_adv    = r_m_valid && (!r_m_end || out_free);
    assign o_ready  = !r_m_valid || m_adv;
    assign take     = i_valid && o_ready;
    assign sum      = r_acc + MVM_SUM_W'(r_m_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid   <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_m_valid <= i_valid;
            end
            // Accumulate; clear at row end
            if (m_adv) begin
                r_acc <= r_m_end ? '0 : sum;
            end
            if (m_adv && r_m_end) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_m_prod <= MVM_PROD_W'($signed(i_entry.value)) *
                        MVM_PROD_W'($signed(i_entry.vec));
            r_m_end  <= i_entry.end_row;
            r_m_row  <= i_entry.row_index;
            r_m_last <= i_entry.last_row;
        end
    end

    // Capture the finished row
    always_ff @(posedge i_clk) begin
        if (m_adv && r_m_end) begin
            r_out_sum  <= sum;
            r_out_row  <= r_m_row;
            r_out_last <= r_m_last;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.row_sum   = r_out_sum;
    assign o_out.row_index = r_out_row;
    assign o_out.last_row  = r_out_last;
endmodule

// ===== test/tb_matrix_vector_multiply.sv =====
// Self-checking testbench for the streamed matrix-vector multiply block.
module tb_matrix_vector_multiply;
    import mvm_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 300;
    localparam int TAIL_ITEMS   = 100;

    typedef struct {
        logic signed [MVM_SUM_W-1:0] total;
        logic [MVM_IDX_W-1:0]        row_idx;
        logic                        is_last;
    } t_row_sum;

    // Tracks vector store, counters and settings; predicts and checks row sums
    class t_mvm_scoreboard;
        logic signed [MVM_VAL_W-1:0] vec_mem [1024];
        bit                          loaded [1024];
        logic signed [MVM_SUM_W-1:0] acc;
        logic [MVM_IDX_W-1:0]        col_pos;
        logic [MVM_IDX_W-1:0]        row_pos;
        logic [MVM_CNT_W-1:0]        cols_reg;
        logic [MVM_CNT_W-1:0]        rows_reg;
        t_row_sum                    sums_due [$];
        int                          errors;

        function new();
            acc      = '0;
            col_pos  = '0;
            row_pos  = '0;
            cols_reg = MVM_COUNT_LIMIT;
            rows_reg = MVM_COUNT_LIMIT;
            errors   = 0;
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        // Zero acts as one, anything above the limit saturates
        function int clamp_count(logic [MVM_CNT_W-1:0] v);
            if (v == '0) return 1;
            if (v > MVM_COUNT_LIMIT) return int'(MVM_COUNT_LIMIT);
            return int'(v);
        endfunction

        function void set_reg(logic idx, logic [MVM_CNT_W-1:0] data);
            if (idx == MVM_CFG_COLS) cols_reg = data;
            else rows_reg = data;
        endfunction

        // Apply one accepted transaction and queue the row sum it closes
        function void note_item(logic mode, logic [MVM_IDX_W-1:0] idx,
                                logic signed [MVM_VAL_W-1:0] val);
            logic signed [MVM_PROD_W-1:0] prod;
            t_row_sum                     done;
            if (mode == MVM_MODE_LOAD) begin
                vec_mem[idx] = val;
                loaded[idx]  = 1'b1;
                return;
            end
            prod = val * vec_mem[col_pos];
            acc  = acc + prod;
            if (int'(col_pos) + 1 < clamp_count(cols_reg)) begin
                col_pos = col_pos + 1'b1;
                return;
            end
            done.total   = acc;
            done.row_idx = row_pos;
            done.is_last = (int'(row_pos) + 1 >= clamp_count(rows_reg));
            sums_due.push_back(done);
            acc     = '0;
            col_pos = '0;
            row_pos = done.is_last ? '0 : row_pos + 1'b1;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40) $display("mismatch: %s", what);
        endtask

        // Compare one accepted row sum with the oldest prediction
        task check_row(logic signed [MVM_SUM_W-1:0] total, logic [MVM_IDX_W-1:0] row_idx,
                       logic is_last);
            t_row_sum want;
            if (sums_due.size() == 0) begin
                report($sformatf("unexpected row sum %0d for row %0d", total, row_idx));
                return;
            end
            want = sums_due.pop_front();
            if (total !== want.total)
                report($sformatf("row %0d sum %0d, want %0d", want.row_idx, total, want.total));
            if (row_idx !== want.row_idx)
                report($sformatf("row index %0d, want %0d", row_idx, want.row_idx));
            if (is_last !== want.is_last)
                report($sformatf("row %0d last flag %0b, want %0b", want.row_idx, is_last,
                                 want.is_last));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic                 i_cfg_index;
    logic [MVM_CNT_W-1:0] i_cfg_data;

    mvm_in_if  in_chan ();
    mvm_out_if out_chan ();

    matrix_vector_multiply uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_chan),
        .o_out       (out_chan),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_mvm_scoreboard sb;
    int              src_gap_pct;
    int              sink_stall_pct;
    int              items_sent;
    int              cycle_count;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_matrix_vector_multiply: errors");
            $finish;
        end
    end

    // Drive output ready with random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        out_chan.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                out_chan.ready <= 1'b0;
                stall_left--;
            end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
                out_chan.ready <= 1'b0;
                stall_left = $urandom_range(18, 1) - 1;
            end else begin
                out_chan.ready <= 1'b1;
            end
        end
    end

    // Check every accepted row sum
    always @(posedge i_clk) begin
        if (i_rst_n && out_chan.valid && out_chan.ready)
            sb.check_row(out_chan.row_sum, out_chan.row_index, out_chan.last_row);
    end

    // Offer one transaction, after an optional idle burst, and hold it until taken
    task automatic send_item(logic mode, logic [MVM_IDX_W-1:0] idx,
                             logic signed [MVM_VAL_W-1:0] val);
        if (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
            in_chan.valid <= 1'b0;
            repeat ($urandom_range(18, 1)) @(posedge i_clk);
        end
        in_chan.valid <= 1'b1;
        in_chan.mode  <= mode;
        in_chan.index <= idx;
        in_chan.value <= val;
        do @(posedge i_clk); while (!in_chan.ready);
        sb.note_item(mode, idx, val);
        items_sent++;
    endtask

    function automatic logic signed [MVM_VAL_W-1:0] pick_value(int ext_pct);
        if ($urandom_range(99) < ext_pct) begin
            case ($urandom_range(3))
                0: return 16'sh8000;
                1: return 16'sh7fff;
                2: return 16'sh0000;
                default: return -16'sd1;
            endcase
        end
        return MVM_VAL_W'($urandom_range(16'hffff));
    endfunction

    // Count setting: mostly small, now and then an extreme
    function automatic logic [MVM_CNT_W-1:0] pick_count(int typical_max);
        if ($urandom_range(9) == 0) begin
            case ($urandom_range(3))
                0: return 11'd0;
                1: return 11'd1;
                2: return 11'd1024;
                default: return 11'd2047;
            endcase
        end
        return MVM_CNT_W'($urandom_range(typical_max, 1));
    endfunction

    // Stream matrix elements with random vector loads mixed in
    task automatic feed_matrix(int n_elems, int load_pct, int ext_pct);
        int span;
        span = sb.clamp_count(sb.cols_reg);
        for (int i = 0; i < n_elems; i++) begin
            if ($urandom_range(99) < load_pct) begin
                if ($urandom_range(4) == 0)
                    send_item(MVM_MODE_LOAD, MVM_IDX_W'($urandom_range(1023)),
                              pick_value(ext_pct));
                else
                    send_item(MVM_MODE_LOAD, MVM_IDX_W'($urandom_range(span - 1)),
                              pick_value(ext_pct));
            end
            // never read a vector entry that was not loaded
            if (!sb.loaded[sb.col_pos])
                send_item(MVM_MODE_LOAD, sb.col_pos, pick_value(ext_pct));
            send_item(MVM_MODE_MATRIX, MVM_IDX_W'($urandom_range(1023)), pick_value(ext_pct));
        end
    endtask

    // Drop valid and let every pending row sum and in-flight element finish
    task automatic drain();
        in_chan.valid <= 1'b0;
        while (sb.sums_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write both registers on consecutive edges
    task automatic cfg_pair(logic [MVM_CNT_W-1:0] cols, logic [MVM_CNT_W-1:0] rows);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= MVM_CFG_COLS;
        i_cfg_data  <= cols;
        @(posedge i_clk);
        i_cfg_index <= MVM_CFG_ROWS;
        i_cfg_data  <= rows;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(MVM_CFG_COLS, cols);
        sb.set_reg(MVM_CFG_ROWS, rows);
    endtask

    // Main sequence
    initial begin
        int rand_start;
        bit tail;
        sb             = new();
        items_sent     = 0;
        src_gap_pct    = 0;
        sink_stall_pct = 0;
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= MVM_CFG_COLS;
        i_cfg_data     <= '0;
        in_chan.valid  <= 1'b0;
        in_chan.mode   <= MVM_MODE_LOAD;
        in_chan.index  <= '0;
        in_chan.value  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme operands, high store index, load in the middle of a row
        src_gap_pct    = 20;
        sink_stall_pct = 20;
        cfg_pair(11'd4, 11'd3);
        send_item(MVM_MODE_LOAD, 10'd0, 16'sh8000);
        send_item(MVM_MODE_LOAD, 10'd1, 16'sh7fff);
        send_item(MVM_MODE_LOAD, 10'd2, 16'sh0100);
        send_item(MVM_MODE_LOAD, 10'd3, -16'sd1);
        send_item(MVM_MODE_LOAD, 10'd1023, 16'sh5a5a);
        repeat (4) send_item(MVM_MODE_MATRIX, MVM_IDX_W'($urandom_range(1023)), 16'sh8000);
        repeat (4) send_item(MVM_MODE_MATRIX, MVM_IDX_W'($urandom_range(1023)), 16'sh7fff);
        send_item(MVM_MODE_MATRIX, 10'd0, -16'sd1);
        send_item(MVM_MODE_MATRIX, 10'd1023, 16'sh0001);
        send_item(MVM_MODE_LOAD, 10'd3, 16'sh0080);
        send_item(MVM_MODE_MATRIX, 10'd0, 16'sh0100);
        send_item(MVM_MODE_MATRIX, 10'd1023, 16'sh8000);
        drain();

        // Single column over every row; zero columns acts as one, row index wraps
        cfg_pair(11'd0, 11'd2047);
        feed_matrix(1030, 5, 20);
        drain();

        // Random phases; settings change between phases, often with a row half done
        rand_start = items_sent;
        while (items_sent - rand_start < RANDOM_ITEMS) begin
            tail = (items_sent - rand_start) > RANDOM_ITEMS - TAIL_ITEMS;
            if (tail || $urandom_range(2) == 0) src_gap_pct = 0;
            else src_gap_pct = $urandom_range(40, 5);
            if (tail || $urandom_range(2) == 0) sink_stall_pct = 0;
            else sink_stall_pct = $urandom_range(40, 5);
            cfg_pair(pick_count(12), pick_count(6));
            feed_matrix($urandom_range(60, 10), $urandom_range(30), $urandom_range(25));
            drain();
        end

        if (sb.errors == 0) begin
            $display("tb_matrix_vector_multiply: clean");
        end else begin
            $display("tb_matrix_vector_multiply: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mvm_pkg.sv
sv/mvm_in_if.sv
sv/mvm_out_if.sv
sv/mvm_ram.sv
sv/mvm_front.sv
sv/mvm_queue.sv
sv/mvm_back.sv
sv/matrix_vector_multiply.sv
test/tb_matrix_vector_multiply.sv
